### src/weierstrass_admissible_transform_assert.svh
// Assertion macros for the Weierstrass transform block, clocked on aclk, off in reset.
`ifndef WEIERSTRASS_ADMISSIBLE_TRANSFORM_ASSERT_SVH
`define WEIERSTRASS_ADMISSIBLE_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define WAT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define WAT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/wat_pkg.sv
// Shared types, constants, modular helpers and microcode for the Weierstrass transform.
`timescale 1ns / 1ps
`default_nettype none

package wat_pkg;

    localparam int RES_W   = 16;
    localparam int PROD_W  = 2 * RES_W;
    localparam int MM_CW   = $clog2(PROD_W);
    localparam int SLOT_N  = 32;
    localparam int SLOT_AW = $clog2(SLOT_N);
    localparam int PC_W    = 7;
    localparam int IMM_W   = 5;

    typedef logic [RES_W-1:0]   res_t;
    typedef logic [SLOT_AW-1:0] slot_t;
    typedef logic [PC_W-1:0]    pc_t;
    typedef logic [IMM_W-1:0]   imm_t;
    typedef logic [MM_CW-1:0]   mm_cnt_t;

    localparam mm_cnt_t MM_LAST = mm_cnt_t'(PROD_W - 1);

    typedef struct packed {
        res_t scale_u;
        res_t shift_r;
        res_t shear_s;
        res_t shift_t;
        res_t in_a1;
        res_t in_a2;
        res_t in_a3;
        res_t in_a4;
        res_t in_a6;
    } in_item_t;

    typedef struct packed {
        res_t out_a1;
        res_t out_a2;
        res_t out_a3;
        res_t out_a4;
        res_t out_a6;
        logic nonsingular;
        logic bad_scale;
    } out_item_t;

    // request to / response from the shared multiply-reduce unit
    typedef struct packed {
        logic start;
        res_t op_a;
        res_t op_b;
        res_t divisor;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        res_t rem;
        res_t quo;
    } mm_rsp_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MUL,
        OP_MULK,
        OP_ADD,
        OP_SUB,
        OP_INV,
        OP_GCD,
        OP_END
    } opc_t;

    typedef struct packed {
        opc_t  opc;
        slot_t dst;
        slot_t src_a;
        slot_t src_b;
        imm_t  imm;
    } uop_t;

    // scratch slots; the first nine match the input fields in order
    localparam slot_t SL_U  = slot_t'(0);
    localparam slot_t SL_R  = slot_t'(1);
    localparam slot_t SL_S  = slot_t'(2);
    localparam slot_t SL_T  = slot_t'(3);
    localparam slot_t SL_A1 = slot_t'(4);
    localparam slot_t SL_A2 = slot_t'(5);
    localparam slot_t SL_A3 = slot_t'(6);
    localparam slot_t SL_A4 = slot_t'(7);
    localparam slot_t SL_A6 = slot_t'(8);
    localparam slot_t SL_V1 = slot_t'(9);
    localparam slot_t SL_V2 = slot_t'(10);
    localparam slot_t SL_V3 = slot_t'(11);
    localparam slot_t SL_V4 = slot_t'(12);
    localparam slot_t SL_V6 = slot_t'(13);
    localparam slot_t SL_RR = slot_t'(14);
    localparam slot_t SL_X  = slot_t'(15);
    localparam slot_t SL_Y  = slot_t'(16);
    localparam slot_t SL_Z  = slot_t'(17);
    localparam slot_t SL_C1 = slot_t'(18);
    localparam slot_t SL_C2 = slot_t'(19);
    localparam slot_t SL_C3 = slot_t'(20);
    localparam slot_t SL_C4 = slot_t'(21);
    localparam slot_t SL_C6 = slot_t'(22);
    localparam slot_t SL_B2 = slot_t'(23);
    localparam slot_t SL_B4 = slot_t'(24);
    localparam slot_t SL_B6 = slot_t'(25);
    localparam slot_t SL_B8 = slot_t'(26);
    localparam slot_t SL_D  = slot_t'(27);

    localparam imm_t K0  = imm_t'(0);
    localparam imm_t K2  = imm_t'(2);
    localparam imm_t K3  = imm_t'(3);
    localparam imm_t K4  = imm_t'(4);
    localparam imm_t K8  = imm_t'(8);
    localparam imm_t K9  = imm_t'(9);
    localparam imm_t K27 = imm_t'(27);

    // a + b mod n, both below n
    function automatic res_t add_mod(input res_t a, input res_t b, input res_t n);
        logic [RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[RES_W-1:0];
    endfunction

    // a - b mod n, both below n
    function automatic res_t sub_mod(input res_t a, input res_t b, input res_t n);
        logic [RES_W:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else        s = {1'b0, a} + {1'b0, n} - {1'b0, b};
        return s[RES_W-1:0];
    endfunction

    function automatic uop_t uo(input opc_t o, input slot_t d, input slot_t a,
                                input slot_t b, input imm_t k);
        uop_t u;
        u.opc   = o;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        u.imm   = k;
        return u;
    endfunction

    function automatic uop_t u_ld(input slot_t d);
        return uo(OP_LOAD, d, SL_X, SL_X, K0);
    endfunction

    function automatic uop_t u_mul(input slot_t d, input slot_t a, input slot_t b);
        return uo(OP_MUL, d, a, b, K0);
    endfunction

    function automatic uop_t u_mulk(input slot_t d, input imm_t k, input slot_t b);
        return uo(OP_MULK, d, SL_X, b, k);
    endfunction

    function automatic uop_t u_add(input slot_t d, input slot_t a, input slot_t b);
        return uo(OP_ADD, d, a, b, K0);
    endfunction

    function automatic uop_t u_sub(input slot_t d, input slot_t a, input slot_t b);
        return uo(OP_SUB, d, a, b, K0);
    endfunction

    // microcode: reduce inputs, invert u, transform, discriminant, unit test
    function automatic uop_t prog_rom(input pc_t pc);
        uop_t u;
        u = uo(OP_END, SL_X, SL_X, SL_X, K0);
        case (pc)
            7'd0:  u = u_ld(SL_U);
            7'd1:  u = u_ld(SL_R);
            7'd2:  u = u_ld(SL_S);
            7'd3:  u = u_ld(SL_T);
            7'd4:  u = u_ld(SL_A1);
            7'd5:  u = u_ld(SL_A2);
            7'd6:  u = u_ld(SL_A3);
            7'd7:  u = u_ld(SL_A4);
            7'd8:  u = u_ld(SL_A6);
            7'd9:  u = uo(OP_INV, SL_V1, SL_U, SL_U, K0);
            7'd10: u = u_mul(SL_V2, SL_V1, SL_V1);
            7'd11: u = u_mul(SL_V3, SL_V2, SL_V1);
            7'd12: u = u_mul(SL_V4, SL_V2, SL_V2);
            7'd13: u = u_mul(SL_V6, SL_V3, SL_V3);
            7'd14: u = u_mul(SL_RR, SL_R, SL_R);
            7'd15: u = u_mulk(SL_X, K2, SL_S);
            7'd16: u = u_add(SL_X, SL_A1, SL_X);
            7'd17: u = u_mul(SL_C1, SL_X, SL_V1);
            7'd18: u = u_mulk(SL_X, K3, SL_R);
            7'd19: u = u_add(SL_X, SL_A2, SL_X);
            7'd20: u = u_mul(SL_Y, SL_S, SL_A1);
            7'd21: u = u_mul(SL_Z, SL_S, SL_S);
            7'd22: u = u_add(SL_Y, SL_Y, SL_Z);
            7'd23: u = u_sub(SL_X, SL_X, SL_Y);
            7'd24: u = u_mul(SL_C2, SL_X, SL_V2);
            7'd25: u = u_mul(SL_X, SL_R, SL_A1);
            7'd26: u = u_add(SL_X, SL_A3, SL_X);
            7'd27: u = u_mulk(SL_Y, K2, SL_T);
            7'd28: u = u_add(SL_X, SL_X, SL_Y);
            7'd29: u = u_mul(SL_C3, SL_X, SL_V3);
            7'd30: u = u_mulk(SL_X, K2, SL_R);
            7'd31: u = u_mul(SL_X, SL_X, SL_A2);
            7'd32: u = u_add(SL_X, SL_A4, SL_X);
            7'd33: u = u_mulk(SL_Y, K3, SL_RR);
            7'd34: u = u_add(SL_X, SL_X, SL_Y);
            7'd35: u = u_mul(SL_Y, SL_S, SL_A3);
            7'd36: u = u_sub(SL_X, SL_X, SL_Y);
            7'd37: u = u_mul(SL_Y, SL_R, SL_S);
            7'd38: u = u_add(SL_Y, SL_T, SL_Y);
            7'd39: u = u_mul(SL_Y, SL_Y, SL_A1);
            7'd40: u = u_sub(SL_X, SL_X, SL_Y);
            7'd41: u = u_mulk(SL_Y, K2, SL_S);
            7'd42: u = u_mul(SL_Y, SL_Y, SL_T);
            7'd43: u = u_sub(SL_X, SL_X, SL_Y);
            7'd44: u = u_mul(SL_C4, SL_X, SL_V4);
            7'd45: u = u_mul(SL_X, SL_R, SL_A4);
            7'd46: u = u_add(SL_X, SL_A6, SL_X);
            7'd47: u = u_mul(SL_Y, SL_RR, SL_A2);
            7'd48: u = u_add(SL_X, SL_X, SL_Y);
            7'd49: u = u_mul(SL_Y, SL_RR, SL_R);
            7'd50: u = u_add(SL_X, SL_X, SL_Y);
            7'd51: u = u_mul(SL_Y, SL_T, SL_A3);
            7'd52: u = u_sub(SL_X, SL_X, SL_Y);
            7'd53: u = u_mul(SL_Y, SL_T, SL_T);
            7'd54: u = u_sub(SL_X, SL_X, SL_Y);
            7'd55: u = u_mul(SL_Y, SL_R, SL_T);
            7'd56: u = u_mul(SL_Y, SL_Y, SL_A1);
            7'd57: u = u_sub(SL_X, SL_X, SL_Y);
            7'd58: u = u_mul(SL_C6, SL_X, SL_V6);
            7'd59: u = u_mul(SL_X, SL_C1, SL_C1);
            7'd60: u = u_mulk(SL_Y, K4, SL_C2);
            7'd61: u = u_add(SL_B2, SL_X, SL_Y);
            7'd62: u = u_mulk(SL_X, K2, SL_C4);
            7'd63: u = u_mul(SL_Y, SL_C1, SL_C3);
            7'd64: u = u_add(SL_B4, SL_X, SL_Y);
            7'd65: u = u_mul(SL_X, SL_C3, SL_C3);
            7'd66: u = u_mulk(SL_Y, K4, SL_C6);
            7'd67: u = u_add(SL_B6, SL_X, SL_Y);
            7'd68: u = u_mul(SL_X, SL_C1, SL_C1);
            7'd69: u = u_mul(SL_X, SL_X, SL_C6);
            7'd70: u = u_mulk(SL_Y, K4, SL_C2);
            7'd71: u = u_mul(SL_Y, SL_Y, SL_C6);
            7'd72: u = u_add(SL_B8, SL_X, SL_Y);
            7'd73: u = u_mul(SL_X, SL_C2, SL_C3);
            7'd74: u = u_mul(SL_X, SL_X, SL_C3);
            7'd75: u = u_add(SL_B8, SL_B8, SL_X);
            7'd76: u = u_mul(SL_X, SL_C1, SL_C3);
            7'd77: u = u_mul(SL_X, SL_X, SL_C4);
            7'd78: u = u_sub(SL_B8, SL_B8, SL_X);
            7'd79: u = u_mul(SL_X, SL_C4, SL_C4);
            7'd80: u = u_sub(SL_B8, SL_B8, SL_X);
            7'd81: u = u_mulk(SL_X, K9, SL_B2);
            7'd82: u = u_mul(SL_Y, SL_B4, SL_B6);
            7'd83: u = u_mul(SL_D, SL_X, SL_Y);
            7'd84: u = u_mul(SL_X, SL_B2, SL_B2);
            7'd85: u = u_mul(SL_X, SL_X, SL_B8);
            7'd86: u = u_sub(SL_D, SL_D, SL_X);
            7'd87: u = u_mulk(SL_X, K8, SL_B4);
            7'd88: u = u_mul(SL_Y, SL_B4, SL_B4);
            7'd89: u = u_mul(SL_X, SL_X, SL_Y);
            7'd90: u = u_sub(SL_D, SL_D, SL_X);
            7'd91: u = u_mulk(SL_X, K27, SL_B6);
            7'd92: u = u_mul(SL_X, SL_X, SL_B6);
            7'd93: u = u_sub(SL_D, SL_D, SL_X);
            7'd94: u = uo(OP_GCD, SL_X, SL_D, SL_D, K0);
            default: u = uo(OP_END, SL_X, SL_X, SL_X, K0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### src/wat_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module wat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### src/wat_mulmod.sv
// Shared multiply-reduce unit: (a*b) div/mod d, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module wat_mulmod (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire wat_pkg::mm_req_t req,
    output wat_pkg::mm_rsp_t      rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    wat_pkg::mm_cnt_t               cnt_reg;
    logic [wat_pkg::PROD_W-1:0]     prod_reg;
    wat_pkg::res_t                  rem_reg;
    wat_pkg::res_t                  quo_reg;
    wat_pkg::res_t                  div_reg;

    logic [wat_pkg::RES_W:0]        trial;
    logic [wat_pkg::RES_W:0]        diff;
    logic                           fits;
    wat_pkg::res_t                  rem_next;

    // restoring step: remainder stays below the divisor
    always_comb begin
        trial    = {rem_reg, prod_reg[wat_pkg::PROD_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        diff     = trial - {1'b0, div_reg};
        rem_next = fits ? diff[wat_pkg::RES_W-1:0] : trial[wat_pkg::RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                prod_reg <= wat_pkg::PROD_W'(req.op_a) * wat_pkg::PROD_W'(req.op_b);
                div_reg  <= req.divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= {prod_reg[wat_pkg::PROD_W-2:0], 1'b0};
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[wat_pkg::RES_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == wat_pkg::MM_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{busy: busy_reg, done: done_reg, rem: rem_reg, quo: quo_reg};

endmodule

`default_nettype wire

### src/weierstrass_admissible_transform.sv
// Top level: microcoded sequencer over a scratch RAM and one multiply-reduce unit.
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   s_data  (in_item_t)
//  m_       out  m_valid / m_ready   m_data  (out_item_t)
//  cfg_     in   cfg_valid/cfg_ready cfg_data (modulus)
//
// One beat at a time. Each multiply-reduce passes fetch, operand read, start,
// 32 reduction steps in the shared unit and done; add/sub pass fetch and execute.
// The program runs 65 of them and 28 add/subs, plus two Euclid runs of at most about
// 23 quotient steps, each a division and a multiply in the shared unit.
// Sync active-low reset; a finished result waits in the output register while the
// next beat is taken. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
`include "weierstrass_admissible_transform_assert.svh"

module weierstrass_admissible_transform (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wat_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wat_pkg::out_item_t       m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire wat_pkg::res_t       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_E_TEST,
        S_E_DIV,
        S_E_MUL,
        S_DONE
    } state_t;

    state_t              state_reg;
    wat_pkg::pc_t        pc_reg;
    wat_pkg::in_item_t   in_reg;
    wat_pkg::res_t       modulus_reg;
    wat_pkg::mm_req_t    req_reg;
    wat_pkg::mm_rsp_t    rsp;
    logic                bad_reg;
    logic                ok_reg;
    logic                m_valid_reg;
    wat_pkg::out_item_t  m_data_reg;
    wat_pkg::res_t       er0_reg;
    wat_pkg::res_t       er1_reg;
    wat_pkg::res_t       ec0_reg;
    wat_pkg::res_t       ec1_reg;
    wat_pkg::res_t       rtmp_reg;
    wat_pkg::res_t       c1_reg;
    wat_pkg::res_t       c2_reg;
    wat_pkg::res_t       c3_reg;
    wat_pkg::res_t       c4_reg;
    wat_pkg::res_t       c6_reg;

    wat_pkg::uop_t       op;
    wat_pkg::res_t       n_eff;
    wat_pkg::res_t       rd_a;
    wat_pkg::res_t       rd_b;
    wat_pkg::res_t       ex_a;
    wat_pkg::res_t       ex_b;
    wat_pkg::res_t       fld;
    logic                we;
    wat_pkg::res_t       wdata;
    logic                mm_start;

    assign op        = wat_pkg::prog_rom(pc_reg);
    assign n_eff     = (modulus_reg < wat_pkg::res_t'(2)) ? wat_pkg::res_t'(2) : modulus_reg;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    wat_ram #(
        .WIDTH (wat_pkg::RES_W),
        .DEPTH (wat_pkg::SLOT_N)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (op.dst),
        .wdata   (wdata),
        .raddr_a (op.src_a),
        .raddr_b (op.src_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    wat_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    // input field picked by the load's destination slot
    always_comb begin
        case (op.dst)
            wat_pkg::SL_U:  fld = in_reg.scale_u;
            wat_pkg::SL_R:  fld = in_reg.shift_r;
            wat_pkg::SL_S:  fld = in_reg.shear_s;
            wat_pkg::SL_T:  fld = in_reg.shift_t;
            wat_pkg::SL_A1: fld = in_reg.in_a1;
            wat_pkg::SL_A2: fld = in_reg.in_a2;
            wat_pkg::SL_A3: fld = in_reg.in_a3;
            wat_pkg::SL_A4: fld = in_reg.in_a4;
            wat_pkg::SL_A6: fld = in_reg.in_a6;
            default:        fld = '0;
        endcase
    end

    always_comb begin
        case (op.opc)
            wat_pkg::OP_LOAD: begin
                ex_a = fld;
                ex_b = wat_pkg::res_t'(1);
            end
            wat_pkg::OP_MULK: begin
                ex_a = wat_pkg::res_t'(op.imm);
                ex_b = rd_b;
            end
            default: begin
                ex_a = rd_a;
                ex_b = rd_b;
            end
        endcase
    end

    // start pulse to the shared unit
    always_comb begin
        mm_start = 1'b0;
        case (state_reg)
            S_EXEC: begin
                mm_start = (op.opc == wat_pkg::OP_LOAD) || (op.opc == wat_pkg::OP_MUL)
                           || (op.opc == wat_pkg::OP_MULK);
            end
            S_E_TEST: begin
                mm_start = (er1_reg != '0);
            end
            S_E_DIV: begin
                mm_start = rsp.done;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    // scratch write-back
    always_comb begin
        we    = 1'b0;
        wdata = rsp.rem;
        case (state_reg)
            S_EXEC: begin
                if (op.opc == wat_pkg::OP_ADD) begin
                    we    = 1'b1;
                    wdata = wat_pkg::add_mod(rd_a, rd_b, n_eff);
                end else if (op.opc == wat_pkg::OP_SUB) begin
                    we    = 1'b1;
                    wdata = wat_pkg::sub_mod(rd_a, rd_b, n_eff);
                end
            end
            S_WAIT: begin
                we = rsp.done;
            end
            S_E_TEST: begin
                if (er1_reg == '0 && op.opc == wat_pkg::OP_INV
                        && er0_reg == wat_pkg::res_t'(1)) begin
                    we    = 1'b1;
                    wdata = ec0_reg;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            req_reg.start <= 1'b0;
            modulus_reg   <= wat_pkg::res_t'(2);
            bad_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            pc_reg        <= '0;
        end else begin
            req_reg.start <= mm_start;
            if (cfg_valid) begin
                modulus_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (we) begin
                case (op.dst)
                    wat_pkg::SL_C1: c1_reg <= wdata;
                    wat_pkg::SL_C2: c2_reg <= wdata;
                    wat_pkg::SL_C3: c3_reg <= wdata;
                    wat_pkg::SL_C4: c4_reg <= wdata;
                    wat_pkg::SL_C6: c6_reg <= wdata;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        pc_reg    <= '0;
                        bad_reg   <= 1'b0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    case (op.opc)
                        wat_pkg::OP_LOAD, wat_pkg::OP_MUL, wat_pkg::OP_MULK: begin
                            req_reg.op_a    <= ex_a;
                            req_reg.op_b    <= ex_b;
                            req_reg.divisor <= n_eff;
                            state_reg       <= S_WAIT;
                        end
                        wat_pkg::OP_ADD, wat_pkg::OP_SUB: begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= S_FETCH;
                        end
                        wat_pkg::OP_INV, wat_pkg::OP_GCD: begin
                            er0_reg   <= n_eff;
                            er1_reg   <= rd_a;
                            ec0_reg   <= '0;
                            ec1_reg   <= wat_pkg::res_t'(1);
                            state_reg <= S_E_TEST;
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (rsp.done) begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_FETCH;
                    end
                end
                S_E_TEST: begin
                    if (er1_reg == '0) begin
                        // gcd sits in er0; inverse of the operand in ec0
                        if (op.opc == wat_pkg::OP_INV) begin
                            if (er0_reg == wat_pkg::res_t'(1)) begin
                                pc_reg    <= pc_reg + 1'b1;
                                state_reg <= S_FETCH;
                            end else begin
                                bad_reg   <= 1'b1;
                                state_reg <= S_DONE;
                            end
                        end else begin
                            ok_reg    <= (er0_reg == wat_pkg::res_t'(1));
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= S_FETCH;
                        end
                    end else begin
                        req_reg.op_a    <= er0_reg;
                        req_reg.op_b    <= wat_pkg::res_t'(1);
                        req_reg.divisor <= er1_reg;
                        state_reg       <= S_E_DIV;
                    end
                end
                S_E_DIV: begin
                    if (rsp.done) begin
                        rtmp_reg        <= rsp.rem;
                        req_reg.op_a    <= rsp.quo;
                        req_reg.op_b    <= ec1_reg;
                        req_reg.divisor <= n_eff;
                        state_reg       <= S_E_MUL;
                    end
                end
                S_E_MUL: begin
                    if (rsp.done) begin
                        // coefficients kept reduced mod n
                        er0_reg   <= er1_reg;
                        er1_reg   <= rtmp_reg;
                        ec0_reg   <= ec1_reg;
                        ec1_reg   <= wat_pkg::sub_mod(ec0_reg, rsp.rem, n_eff);
                        state_reg <= S_E_TEST;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        if (bad_reg) begin
                            m_data_reg <= '{out_a1: '0, out_a2: '0, out_a3: '0,
                                            out_a4: '0, out_a6: '0,
                                            nonsingular: 1'b0, bad_scale: 1'b1};
                        end else begin
                            m_data_reg <= '{out_a1: c1_reg, out_a2: c2_reg,
                                            out_a3: c3_reg, out_a4: c4_reg,
                                            out_a6: c6_reg, nonsingular: ok_reg,
                                            bad_scale: 1'b0};
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `WAT_ASSERT_NOW(a_bad_zero, m_valid && m_data.bad_scale,
        m_data.out_a1 == '0 && m_data.out_a2 == '0 && m_data.out_a3 == '0 &&
        m_data.out_a4 == '0 && m_data.out_a6 == '0 && !m_data.nonsingular,
        "bad scale with nonzero result")
    `WAT_ASSERT_NOW(a_reduced, m_valid && !m_data.bad_scale,
        m_data.out_a1 < n_eff && m_data.out_a2 < n_eff && m_data.out_a3 < n_eff &&
        m_data.out_a4 < n_eff && m_data.out_a6 < n_eff, "result not reduced mod n")
    `WAT_ASSERT_NOW(a_idle_unit, s_ready, !rsp.busy, "unit busy while idle")
    `WAT_ASSERT_NEXT(a_one_beat, s_valid && s_ready, !s_ready, "second beat taken")

endmodule

`default_nettype wire

### bench/weierstrass_admissible_transform_tb.sv
// Testbench for the Weierstrass change-of-variables block: directed and random curves, scoreboarded.
`timescale 1ns / 1ps
`default_nettype none

module weierstrass_admissible_transform_tb;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    wat_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    wat_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    wat_pkg::res_t      cfg_data = '0;

    wat_pkg::out_item_t curve_q[$];
    wat_pkg::res_t      ring_mod = wat_pkg::res_t'(2);
    int                 err_cnt = 0;
    longint             cycle_cnt = 0;
    int                 burst_left = 0;
    int                 stall_mode = 0;

    weierstrass_admissible_transform dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
                                             longint unsigned n);
        return ((a % n) * (b % n)) % n;
    endfunction

    function automatic longint unsigned addm(longint unsigned a, longint unsigned b,
                                             longint unsigned n);
        return (a % n + b % n) % n;
    endfunction

    function automatic longint unsigned subm(longint unsigned a, longint unsigned b,
                                             longint unsigned n);
        return (a % n + n - b % n) % n;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned tmp;
        while (b != 0) begin
            tmp = a % b;
            a = b;
            b = tmp;
        end
        return a;
    endfunction

    function automatic longint unsigned unit_inverse(longint unsigned a, longint unsigned n);
        longint r0, r1, c0, c1, q, tmp;
        r0 = n; r1 = a % n; c0 = 0; c1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1; r0 = r1; r1 = tmp;
            tmp = c0 - q * c1; c0 = c1; c1 = tmp;
        end
        c0 = c0 % longint'(n);
        if (c0 < 0) c0 += n;
        return c0;
    endfunction

    function automatic wat_pkg::out_item_t transform_curve(wat_pkg::in_item_t x,
                                                           wat_pkg::res_t modv);
        longint unsigned n, u, r, s, t, a1, a2, a3, a4, a6;
        longint unsigned v1, v2, v3, v4, v6, rr, w, b2, b4, b6, b8, d;
        wat_pkg::out_item_t o;
        o = '0;
        n = (modv < 2) ? 2 : modv;
        u = x.scale_u % n; r = x.shift_r % n; s = x.shear_s % n; t = x.shift_t % n;
        a1 = x.in_a1 % n; a2 = x.in_a2 % n; a3 = x.in_a3 % n;
        a4 = x.in_a4 % n; a6 = x.in_a6 % n;
        if (gcd_of(u, n) != 1) begin
            o.bad_scale = 1'b1;
            return o;
        end
        v1 = unit_inverse(u, n);
        v2 = mulm(v1, v1, n); v3 = mulm(v2, v1, n);
        v4 = mulm(v2, v2, n); v6 = mulm(v3, v3, n);
        rr = mulm(r, r, n);
        o.out_a1 = wat_pkg::res_t'(mulm(addm(a1, mulm(2, s, n), n), v1, n));
        w = subm(addm(a2, mulm(3, r, n), n), addm(mulm(s, a1, n), mulm(s, s, n), n), n);
        o.out_a2 = wat_pkg::res_t'(mulm(w, v2, n));
        w = addm(addm(a3, mulm(r, a1, n), n), mulm(2, t, n), n);
        o.out_a3 = wat_pkg::res_t'(mulm(w, v3, n));
        w = addm(addm(a4, mulm(mulm(2, r, n), a2, n), n), mulm(3, rr, n), n);
        w = subm(w, mulm(s, a3, n), n);
        w = subm(w, mulm(addm(t, mulm(r, s, n), n), a1, n), n);
        w = subm(w, mulm(mulm(2, s, n), t, n), n);
        o.out_a4 = wat_pkg::res_t'(mulm(w, v4, n));
        w = addm(addm(a6, mulm(r, a4, n), n), addm(mulm(rr, a2, n), mulm(rr, r, n), n), n);
        w = subm(w, addm(mulm(t, a3, n), mulm(t, t, n), n), n);
        w = subm(w, mulm(mulm(r, t, n), a1, n), n);
        o.out_a6 = wat_pkg::res_t'(mulm(w, v6, n));
        b2 = addm(mulm(o.out_a1, o.out_a1, n), mulm(4, o.out_a2, n), n);
        b4 = addm(mulm(2, o.out_a4, n), mulm(o.out_a1, o.out_a3, n), n);
        b6 = addm(mulm(o.out_a3, o.out_a3, n), mulm(4, o.out_a6, n), n);
        b8 = addm(mulm(mulm(o.out_a1, o.out_a1, n), o.out_a6, n),
                  mulm(mulm(4, o.out_a2, n), o.out_a6, n), n);
        b8 = addm(b8, mulm(mulm(o.out_a2, o.out_a3, n), o.out_a3, n), n);
        b8 = subm(b8, mulm(mulm(o.out_a1, o.out_a3, n), o.out_a4, n), n);
        b8 = subm(b8, mulm(o.out_a4, o.out_a4, n), n);
        d = mulm(mulm(9, b2, n), mulm(b4, b6, n), n);
        d = subm(d, mulm(mulm(b2, b2, n), b8, n), n);
        d = subm(d, mulm(mulm(8, b4, n), mulm(b4, b4, n), n), n);
        d = subm(d, mulm(mulm(27, b6, n), b6, n), n);
        o.nonsingular = (gcd_of(n, d) == 1);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // scoreboard, receiver stall pattern, cycle limit
    always @(posedge aclk) begin
        wat_pkg::out_item_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) ring_mod = cfg_data;
            if (s_valid && s_ready) curve_q = {curve_q, transform_curve(s_data, ring_mod)};
            if (m_valid && m_ready) begin
                if (curve_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = curve_q.pop_front();
                    if (m_data.out_a1 != want.out_a1)
                        report_mismatch("out_a1", m_data.out_a1, want.out_a1);
                    if (m_data.out_a2 != want.out_a2)
                        report_mismatch("out_a2", m_data.out_a2, want.out_a2);
                    if (m_data.out_a3 != want.out_a3)
                        report_mismatch("out_a3", m_data.out_a3, want.out_a3);
                    if (m_data.out_a4 != want.out_a4)
                        report_mismatch("out_a4", m_data.out_a4, want.out_a4);
                    if (m_data.out_a6 != want.out_a6)
                        report_mismatch("out_a6", m_data.out_a6, want.out_a6);
                    if (m_data.nonsingular != want.nonsingular)
                        report_mismatch("nonsingular", m_data.nonsingular, want.nonsingular);
                    if (m_data.bad_scale != want.bad_scale)
                        report_mismatch("bad_scale", m_data.bad_scale, want.bad_scale);
                end
            end
        end
        if ($urandom_range(0, 999) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // returns at the edge that takes the beat
    task automatic send_curve(wat_pkg::in_item_t x);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= x;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (curve_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_modulus(wat_pkg::res_t v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic wat_pkg::res_t pick_residue(wat_pkg::res_t modv);
        int unsigned n;
        n = (modv < 2) ? 2 : modv;
        case ($urandom_range(0, 19))
            0, 1:    return wat_pkg::res_t'($urandom);
            2:       return '0;
            3:       return wat_pkg::res_t'(n - 1);
            4:       return wat_pkg::res_t'(16'hffff);
            5:       return wat_pkg::res_t'(1);
            default: return wat_pkg::res_t'($urandom_range(0, n - 1));
        endcase
    endfunction

    function automatic wat_pkg::in_item_t random_curve(wat_pkg::res_t modv);
        wat_pkg::in_item_t x;
        x.scale_u = pick_residue(modv); x.shift_r = pick_residue(modv);
        x.shear_s = pick_residue(modv); x.shift_t = pick_residue(modv);
        x.in_a1 = pick_residue(modv); x.in_a2 = pick_residue(modv);
        x.in_a3 = pick_residue(modv); x.in_a4 = pick_residue(modv);
        x.in_a6 = pick_residue(modv);
        return x;
    endfunction

    function automatic wat_pkg::in_item_t make_curve(wat_pkg::res_t u, wat_pkg::res_t r,
                                                     wat_pkg::res_t s, wat_pkg::res_t t,
                                                     wat_pkg::res_t a1, wat_pkg::res_t a2,
                                                     wat_pkg::res_t a3, wat_pkg::res_t a4,
                                                     wat_pkg::res_t a6);
        wat_pkg::in_item_t x;
        x = '{u, r, s, t, a1, a2, a3, a4, a6};
        return x;
    endfunction

    task automatic test_reset_modulus();
        send_curve(make_curve(1, 0, 0, 0, 0, 0, 1, 0, 1));
        send_curve(make_curve(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_curve(make_curve(2, 1, 1, 1, 1, 1, 1, 1, 1));
    endtask

    task automatic test_extremes();
        write_modulus(16'hffff);
        send_curve(make_curve(1, 0, 0, 0, 0, 0, 0, 0, 0));   // zero discriminant
        send_curve(make_curve(16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe,
                              16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe));
        send_curve(make_curve(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_curve(make_curve(3, 1, 2, 3, 4, 5, 6, 7, 8));     // 3 divides 65535
        send_curve(make_curve(0, 5, 5, 5, 5, 5, 5, 5, 5));
        send_curve(make_curve(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                              16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
        send_curve(make_curve(16'h5554, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                              16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
        write_modulus(16'd65521);
        send_curve(make_curve(16'd65520, 16'hffff, 16'hfff1, 16'd65520, 1, 1, 0, 16'hfff0, 0));
        send_curve(make_curve(7, 0, 0, 0, 0, 0, 0, 16'd65520, 0));
    endtask

    task automatic test_tiny_moduli();
        write_modulus(16'd0);
        send_curve(make_curve(1, 1, 1, 1, 1, 1, 1, 1, 1));
        send_curve(make_curve(3, 0, 1, 0, 1, 0, 1, 0, 1));
        write_modulus(16'd1);
        send_curve(make_curve(16'hffff, 0, 0, 0, 0, 0, 1, 0, 0));
        send_curve(make_curve(4, 0, 0, 0, 0, 0, 0, 0, 0));
        write_modulus(16'd12);
        send_curve(make_curve(6, 1, 2, 3, 4, 5, 6, 7, 8));     // shares a factor with n
        send_curve(make_curve(5, 11, 11, 11, 11, 11, 11, 11, 11));
        send_curve(make_curve(16'd17, 16'd100, 16'd200, 16'd300, 1, 2, 3, 4, 5));
    endtask

    task automatic test_random_moduli();
        wat_pkg::res_t mods[8];
        wat_pkg::res_t m;
        mods = '{16'd65521, 16'hffff, 16'd3, 16'd12, 16'd1009, 16'd2, 16'd32768, 16'd0};
        for (int p = 0; p < 11; p++) begin
            m = (p < 8) ? mods[p] : wat_pkg::res_t'($urandom_range(2, 65535));
            write_modulus(m);
            for (int k = 0; k < 100; k++) send_curve(random_curve(m));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_modulus();
        test_extremes();
        test_tiny_moduli();
        test_random_moduli();
        drain_results();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/wat_pkg.sv
src/wat_ram.sv
src/wat_mulmod.sv
src/weierstrass_admissible_transform.sv
bench/weierstrass_admissible_transform_tb.sv
